FILE: hdl/ipd_pkg.sv
// ----------------------------------------------------------------------------
// ipd_pkg: shared definitions for the IR pulse detector
// Widths, register reset values, register indexes and the per-step control
// struct passed from the top level to the datapath modules.
// ----------------------------------------------------------------------------
package ipd_pkg;

   localparam int SampleBits = 10;
   localparam int AlphaBits  = 16;
   localparam int TickBits   = 16;
   localparam int RunBits    = 8;
   localparam int CountBits  = 16;

   localparam int CsrAddrBits = 4;
   localparam int CsrDataBits = 32;

   localparam logic [AlphaBits-1:0] AlphaReset   = AlphaBits'(32768);
   localparam logic [TickBits-1:0]  WarmupReset  = TickBits'(1000);
   localparam logic [TickBits-1:0]  TimeoutReset = TickBits'(1000);
   localparam logic [RunBits-1:0]   RunReset     = RunBits'(2);

   typedef enum logic [1:0] {
      RegFilterAlpha  = 2'd0,
      RegWarmupTicks  = 2'd1,
      RegTimeoutTicks = 2'd2,
      RegReversalRun  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic fire;     // request moves into the result register this cycle
      logic active;   // warmup is over, the sample is processed
   } step_ctl_type;

endpackage

FILE: hdl/ipd_filter.sv
// ----------------------------------------------------------------------------
// ipd_filter: first-order low-pass filter
// new = f + floor(alpha * (x - f) / 65536), which equals
// (alpha*x + (65536-alpha)*f) >> 16 exactly, with one signed multiply.
// ----------------------------------------------------------------------------
module ipd_filter (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ipd_pkg::step_ctl_type                 step,
   input  logic [ipd_pkg::SampleBits-1:0]        sample,
   input  logic [ipd_pkg::AlphaBits-1:0]         alpha,
   output logic [ipd_pkg::SampleBits-1:0]        value_out
);

   localparam int DiffBits = ipd_pkg::SampleBits + 1;
   localparam int ProdBits = ipd_pkg::AlphaBits + 1 + DiffBits;
   localparam int StepBits = ProdBits - ipd_pkg::AlphaBits;

   logic [ipd_pkg::SampleBits-1:0] filter_ff;
   logic [ipd_pkg::SampleBits-1:0] filter_in;
   logic signed [DiffBits-1:0]     diff;
   logic signed [ProdBits-1:0]     prod;
   logic signed [StepBits-1:0]     delta;
   logic signed [StepBits-1:0]     sum;

   always_comb begin
      diff  = $signed({1'b0, sample}) - $signed({1'b0, filter_ff});
      prod  = $signed({1'b0, alpha}) * diff;
      delta = prod[ProdBits-1:ipd_pkg::AlphaBits];
      sum   = $signed({{(StepBits-ipd_pkg::SampleBits){1'b0}}, filter_ff}) + delta;
   end

   // hold the value through warmup
   assign value_out = step.active ? sum[ipd_pkg::SampleBits-1:0] : filter_ff;
   assign filter_in = (step.fire && step.active) ? value_out : filter_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_ff <= '0;
      end else begin
         filter_ff <= filter_in;
      end
   end

   a_filter_holds: assert property (@(posedge clock) disable iff (reset)
      !(step.fire && step.active) |=> $stable(filter_ff))
      else $error("filter state moved without a processed request");

endmodule

FILE: hdl/ipd_slope.sv
// ----------------------------------------------------------------------------
// ipd_slope: slope reversal detector and pulse counter
// Tracks falling and rising runs of the filtered value, confirms a reversal
// after reversal_run samples and counts pulses within the timeout window.
// ----------------------------------------------------------------------------
module ipd_slope (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ipd_pkg::step_ctl_type                 step,
   input  logic [ipd_pkg::SampleBits-1:0]        value,
   input  logic [ipd_pkg::TickBits-1:0]          timeout_ticks,
   input  logic [ipd_pkg::RunBits-1:0]           reversal_run,
   output logic                                  pulse,
   output logic [ipd_pkg::CountBits-1:0]         count_out
);

   logic [ipd_pkg::SampleBits-1:0] previous_ff, previous_in;
   logic [ipd_pkg::RunBits-1:0]    falling_ff, falling_in, falling_inc;
   logic [ipd_pkg::RunBits-1:0]    rising_ff, rising_in, rising_inc;
   logic                           direction_ff, direction_in;
   logic [ipd_pkg::TickBits-1:0]   ticks_ff, ticks_in, ticks_inc;
   logic [ipd_pkg::CountBits-1:0]  total_ff, total_in;
   logic                           fall;

   always_comb begin
      falling_inc  = (falling_ff == '1) ? falling_ff : falling_ff + 1'b1;
      rising_inc   = (rising_ff == '1) ? rising_ff : rising_ff + 1'b1;
      ticks_inc    = (ticks_ff == '1) ? ticks_ff : ticks_ff + 1'b1;
      fall         = previous_ff > value;
      previous_in  = previous_ff;
      falling_in   = falling_ff;
      rising_in    = rising_ff;
      direction_in = direction_ff;
      ticks_in     = ticks_ff;
      total_in     = total_ff;
      pulse        = 1'b0;
      if (step.active) begin
         previous_in = value;
         if (fall) begin
            falling_in = falling_inc;
            if (direction_ff && (falling_inc >= reversal_run)) begin
               direction_in = 1'b0;
               rising_in    = '0;
               pulse        = 1'b1;
            end
         end else begin
            rising_in = rising_inc;
            if (!direction_ff && (rising_inc >= reversal_run)) begin
               direction_in = 1'b1;
               falling_in   = '0;
               pulse        = 1'b1;
            end
         end
         if (pulse) begin
            ticks_in = '0;
            if (ticks_inc > timeout_ticks) begin
               total_in = '0;
            end else begin
               total_in = (total_ff == '1) ? total_ff : total_ff + 1'b1;
            end
         end else begin
            ticks_in = ticks_inc;
         end
      end else begin
         // warmup tick restarts the pulse spacing
         ticks_in = '0;
      end
   end

   assign count_out = total_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         previous_ff  <= '0;
         falling_ff   <= '0;
         rising_ff    <= '0;
         direction_ff <= 1'b0;
         ticks_ff     <= '0;
         total_ff     <= '0;
      end else if (step.fire) begin
         previous_ff  <= previous_in;
         falling_ff   <= falling_in;
         rising_ff    <= rising_in;
         direction_ff <= direction_in;
         ticks_ff     <= ticks_in;
         total_ff     <= total_in;
      end
   end

   a_pulse_flips: assert property (@(posedge clock) disable iff (reset)
      (step.fire && pulse) |=> (direction_ff != $past(direction_ff)))
      else $error("pulse without slope direction change");

   a_warmup_clears: assert property (@(posedge clock) disable iff (reset)
      (step.fire && !step.active) |=> (ticks_ff == '0))
      else $error("warmup step left pulse spacing counter running");

   a_pulse_only_active: assert property (@(posedge clock) disable iff (reset)
      pulse |-> step.active)
      else $error("pulse raised during warmup");

endmodule

FILE: hdl/ir_pulse_detector_unit.sv
// ----------------------------------------------------------------------------
// ir_pulse_detector_unit: IR receiver pulse counter
// Low-pass filters 1 ms ADC samples after a warmup period, confirms slope
// reversals and counts pulses spaced within a timeout.
// ----------------------------------------------------------------------------
// The unit takes one sample request per clock cycle while the result side is
// not stalled and returns exactly one result per request, in order. A request
// accepted at one edge lands in the input register; the next free cycle runs
// filter, slope detector and pulse counter and loads the result register.
// Throughput is one request per cycle, set by the state update loop (one
// 17x11 multiply plus add for the filter, then the compare and counter
// update). While a finished result waits to be taken, the input register can
// still take one request; after that req_tready stays low until the result
// side drains.
// Configuration registers (byte addresses): 0x0 filter_alpha, 0x4
// warmup_ticks, 0x8 timeout_ticks, 0xC reversal_run; write them only when
// the unit is idle.
module ir_pulse_detector_unit (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [15:0]                      req_tdata,   // [9:0] sample
   // result channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [31:0]                      rsp_tdata,   // [0] active, [10:1] filtered,
                                                         // [11] pulse_seen,
                                                         // [27:12] pulse_count
   // configuration port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [ipd_pkg::CsrAddrBits-1:0]  csr_paddr,
   input  logic [ipd_pkg::CsrDataBits-1:0]  csr_pwdata,
   output logic [ipd_pkg::CsrDataBits-1:0]  csr_prdata,
   output logic                             csr_pready
);

   localparam int RspBits = 1 + ipd_pkg::SampleBits + 1 + ipd_pkg::CountBits;

   // configuration registers
   logic [ipd_pkg::AlphaBits-1:0] alpha_ff;
   logic [ipd_pkg::TickBits-1:0]  warmup_ticks_ff;
   logic [ipd_pkg::TickBits-1:0]  timeout_ff;
   logic [ipd_pkg::RunBits-1:0]   run_ff;
   logic                          csr_write;
   ipd_pkg::csr_index_type        csr_index;

   // input register and warmup counter
   logic                           req_valid_ff, req_valid_in;
   logic [ipd_pkg::SampleBits-1:0] sample_ff;
   logic [ipd_pkg::TickBits-1:0]   warmup_ff, warmup_in;
   logic                           req_take;
   logic                           out_free;
   ipd_pkg::step_ctl_type          step;

   // datapath results
   logic [ipd_pkg::SampleBits-1:0] filt_value;
   logic                           pulse;
   logic [ipd_pkg::CountBits-1:0]  count;

   // result register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [RspBits-1:0]             rsp_data_ff;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_index  = ipd_pkg::csr_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff        <= ipd_pkg::AlphaReset;
         warmup_ticks_ff <= ipd_pkg::WarmupReset;
         timeout_ff      <= ipd_pkg::TimeoutReset;
         run_ff          <= ipd_pkg::RunReset;
      end else if (csr_write) begin
         case (csr_index)
            ipd_pkg::RegFilterAlpha:  alpha_ff        <= csr_pwdata[ipd_pkg::AlphaBits-1:0];
            ipd_pkg::RegWarmupTicks:  warmup_ticks_ff <= csr_pwdata[ipd_pkg::TickBits-1:0];
            ipd_pkg::RegTimeoutTicks: timeout_ff      <= csr_pwdata[ipd_pkg::TickBits-1:0];
            ipd_pkg::RegReversalRun:  run_ff          <= csr_pwdata[ipd_pkg::RunBits-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         ipd_pkg::RegFilterAlpha:
            csr_prdata = ipd_pkg::CsrDataBits'(alpha_ff);
         ipd_pkg::RegWarmupTicks:
            csr_prdata = ipd_pkg::CsrDataBits'(warmup_ticks_ff);
         ipd_pkg::RegTimeoutTicks:
            csr_prdata = ipd_pkg::CsrDataBits'(timeout_ff);
         ipd_pkg::RegReversalRun:
            csr_prdata = ipd_pkg::CsrDataBits'(run_ff);
         default:
            csr_prdata = '0;
      endcase
   end

   // ---------------- handshake and input register ----------------
   // Advance the held request whenever the result register is empty or
   // being drained; take a new request whenever the input register frees up.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !req_valid_ff || out_free;
   assign req_take   = req_tvalid && req_tready;

   assign step.fire   = req_valid_ff && out_free;
   assign step.active = !(warmup_ff < warmup_ticks_ff);

   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_take) begin
         req_valid_in = 1'b1;
      end else if (out_free) begin
         req_valid_in = 1'b0;
      end
   end

   // warmup_ff stays below 65535 while counting, so no saturation needed
   assign warmup_in = (step.fire && !step.active) ? warmup_ff + 1'b1 : warmup_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         warmup_ff    <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         warmup_ff    <= warmup_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         sample_ff <= req_tdata[ipd_pkg::SampleBits-1:0];
      end
   end

   // ---------------- datapath ----------------
   ipd_filter u_filter (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .sample    (sample_ff),
      .alpha     (alpha_ff),
      .value_out (filt_value)
   );

   ipd_slope u_slope (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .value         (filt_value),
      .timeout_ticks (timeout_ff),
      .reversal_run  (run_ff),
      .pulse         (pulse),
      .count_out     (count)
   );

   // ---------------- result register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step.fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step.fire) begin
         rsp_data_ff <= {count, pulse, filt_value, step.active};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(32-RspBits){1'b0}}, rsp_data_ff};

   // ---------------- checks ----------------
   a_held_request_stays: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && !out_free) |=> req_valid_ff)
      else $error("held request dropped while result side stalled");

   a_no_pulse_in_warmup: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff[0]) |-> !rsp_data_ff[ipd_pkg::SampleBits+1])
      else $error("warmup result carries a pulse flag");

endmodule

FILE: tb/tb_ir_pulse_detector_unit.sv
// ----------------------------------------------------------------------------
// tb_ir_pulse_detector_unit: self-checking bench for the IR pulse detector
// Streams ADC sample requests into the unit and predicts every result with
// an in-bench copy of the filter, slope detector and pulse counter. Covers
// warmup hold and re-entry, filter coefficient extremes, zero and maximum
// reversal runs, zero timeout, long flat stretches against large and small
// timeouts and a dense pulse train, then random waveforms under random
// settings and random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_ir_pulse_detector_unit;

   localparam int CycleLimit = 2000000;

   // Direction that the filtered value last confirmed.
   typedef enum logic {
      SlopeFalling = 1'b0,
      SlopeRising  = 1'b1
   } slope_type;

   // Laid out exactly as rsp_tdata[27:0].
   typedef struct packed {
      logic [ipd_pkg::CountBits-1:0]  pulse_count;
      logic                           pulse_seen;
      logic [ipd_pkg::SampleBits-1:0] filtered;
      logic                           active;
   } detector_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;    // [9:0] sample
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // [0] active, [10:1] filtered, [11] pulse_seen,
                                   // [27:12] pulse_count
   logic                            csr_psel = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite = 1'b0;
   logic [ipd_pkg::CsrAddrBits-1:0] csr_paddr = '0;
   logic [ipd_pkg::CsrDataBits-1:0] csr_pwdata = '0;
   logic [ipd_pkg::CsrDataBits-1:0] csr_prdata;
   logic                            csr_pready;

   // Register copies, updated when the bench writes the block.
   logic [ipd_pkg::AlphaBits-1:0] cfg_alpha;
   logic [ipd_pkg::TickBits-1:0]  cfg_warmup;
   logic [ipd_pkg::TickBits-1:0]  cfg_timeout;
   logic [ipd_pkg::RunBits-1:0]   cfg_run;

   // Detector state copies.
   logic [ipd_pkg::TickBits-1:0]   det_warmup;
   logic [ipd_pkg::SampleBits-1:0] det_filter;
   logic [ipd_pkg::SampleBits-1:0] det_previous;
   logic [ipd_pkg::RunBits-1:0]    det_fall_run;
   logic [ipd_pkg::RunBits-1:0]    det_rise_run;
   slope_type                      det_slope;
   logic [ipd_pkg::TickBits-1:0]   det_ticks;
   logic [ipd_pkg::CountBits-1:0]  det_pulses;

   detector_result_type pending_results[$];
   int failures = 0;
   int cycle_count = 0;
   bit send_idling = 1'b1;
   bit recv_idling = 1'b1;

   ir_pulse_detector_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("status: fail");
         $finish;
      end
   end

   // Stall the result side at random, with a chance of about 30 percent, while idling is on.
   always @(posedge clock) begin
      rsp_tready <= !recv_idling || ($urandom_range(99) >= 30);
   end

   function automatic logic [ipd_pkg::TickBits-1:0] sat_inc16(
      input logic [ipd_pkg::TickBits-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic logic [ipd_pkg::RunBits-1:0] sat_inc8(
      input logic [ipd_pkg::RunBits-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   // Advance the detector copy by one sample and return the result it gives.
   function automatic detector_result_type advance_detector(
      input logic [ipd_pkg::SampleBits-1:0] x);
      detector_result_type r;
      logic [31:0] acc;
      logic pulse;
      r = '0;
      pulse = 1'b0;
      det_ticks = sat_inc16(det_ticks);
      if (det_warmup < cfg_warmup) begin
         // Warmup tick: count it, clear the pulse spacing, hold everything else.
         det_warmup = sat_inc16(det_warmup);
         det_ticks = '0;
      end else begin
         r.active = 1'b1;
         // The sum stays below 2^26, so the shifted value is acc[25:16].
         acc = 32'(cfg_alpha) * 32'(x) + (32'd65536 - 32'(cfg_alpha)) * 32'(det_filter);
         det_filter = acc[25:16];
         if (det_previous > det_filter) begin
            det_fall_run = sat_inc8(det_fall_run);
            if (det_slope == SlopeRising && det_fall_run >= cfg_run) begin
               det_slope = SlopeFalling;
               det_rise_run = '0;
               pulse = 1'b1;
            end
         end else begin
            // No change counts as a rise.
            det_rise_run = sat_inc8(det_rise_run);
            if (det_slope == SlopeFalling && det_rise_run >= cfg_run) begin
               det_slope = SlopeRising;
               det_fall_run = '0;
               pulse = 1'b1;
            end
         end
         det_previous = det_filter;
         if (pulse) begin
            det_pulses = (det_ticks > cfg_timeout) ? '0 : sat_inc16(det_pulses);
            det_ticks = '0;
         end
      end
      r.filtered = det_filter;
      r.pulse_seen = pulse;
      r.pulse_count = det_pulses;
      return r;
   endfunction

   // Predict on each accepted request first, then check each accepted result
   // against the oldest prediction.
   always @(posedge clock) begin : result_check
      detector_result_type want;
      detector_result_type got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            pending_results.push_back(advance_detector(req_tdata[ipd_pkg::SampleBits-1:0]));
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[27:0];
            if (pending_results.size() == 0) begin
               failures++;
               $display("%0t: unexpected result, expected none, got 0x%07h", $time, got);
            end else begin
               want = pending_results.pop_front();
               if (got.active !== want.active) begin
                  failures++;
                  $display("%0t: active expected %0d, got %0d",
                           $time, want.active, got.active);
               end
               if (got.filtered !== want.filtered) begin
                  failures++;
                  $display("%0t: filtered expected %0d, got %0d",
                           $time, want.filtered, got.filtered);
               end
               if (got.pulse_seen !== want.pulse_seen) begin
                  failures++;
                  $display("%0t: pulse_seen expected %0d, got %0d",
                           $time, want.pulse_seen, got.pulse_seen);
               end
               if (got.pulse_count !== want.pulse_count) begin
                  failures++;
                  $display("%0t: pulse_count expected %0d, got %0d",
                           $time, want.pulse_count, got.pulse_count);
               end
            end
         end
      end
   end

   // Offer one request; drop valid only for a random gap, hold it otherwise.
   task automatic send_sample(input logic [15:0] word);
      if (send_idling && $urandom_range(99) < 30) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 30);
      end
      req_tvalid <= 1'b1;
      req_tdata <= word;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_constant(input logic [ipd_pkg::SampleBits-1:0] level,
                                input int unsigned count);
      for (int unsigned i = 0; i < count; i++) begin
         send_sample({6'($urandom), level});
      end
   endtask

   // Stop sending and hold off until every predicted result has arrived.
   // Wait for a clock edge first so the last accepted request is already predicted.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // APB write: setup phase, access phase, then back to idle.
   task automatic write_register(input ipd_pkg::csr_index_type which,
                                 input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= ipd_pkg::CsrAddrBits'({which, 2'b00});
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (which)
         ipd_pkg::RegFilterAlpha:  cfg_alpha = value[ipd_pkg::AlphaBits-1:0];
         ipd_pkg::RegWarmupTicks:  cfg_warmup = value[ipd_pkg::TickBits-1:0];
         ipd_pkg::RegTimeoutTicks: cfg_timeout = value[ipd_pkg::TickBits-1:0];
         ipd_pkg::RegReversalRun:  cfg_run = value[ipd_pkg::RunBits-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Reset defaults: every sample is a warmup tick, results hold zero.
   task automatic test_warmup_hold();
      send_sample(16'h03FF);
      send_sample(16'h0000);
      send_sample(16'hFC00);
      send_sample(16'h0200);
      wait_for_results();
      write_register(ipd_pkg::RegWarmupTicks, 32'h0);
   endtask

   // Coefficient extremes, with out-of-width bits on samples and registers.
   task automatic test_filter_extremes();
      write_register(ipd_pkg::RegFilterAlpha, 32'hFFFF_FFFF);
      write_register(ipd_pkg::RegReversalRun, 32'hFFFF_FF01);
      send_sample(16'h03FF);
      send_sample(16'hFC00);
      send_sample(16'hFFFF);
      wait_for_results();
      write_register(ipd_pkg::RegFilterAlpha, 32'h0);
      send_sample(16'h03FF);
      send_sample(16'h0000);
      wait_for_results();
      write_register(ipd_pkg::RegFilterAlpha, 32'h1);
      send_sample(16'h03FF);
      wait_for_results();
      write_register(ipd_pkg::RegFilterAlpha, 32'hFFFF);
   endtask

   // A run of zero confirms every opposite sample at once.
   task automatic test_zero_run();
      write_register(ipd_pkg::RegReversalRun, 32'h0);
      send_sample(16'h03FF);
      send_sample(16'h0000);
      send_sample(16'h03FF);
      send_sample(16'h0000);
      send_sample(16'h0000);
      wait_for_results();
      write_register(ipd_pkg::RegReversalRun, 32'h1);
   endtask

   // A timeout of zero restarts the count on every pulse.
   task automatic test_zero_timeout();
      write_register(ipd_pkg::RegTimeoutTicks, 32'hABCD_0000);
      send_sample(16'h03FF);
      send_sample(16'h0000);
      send_sample(16'h03FF);
      send_sample(16'h0000);
      wait_for_results();
      write_register(ipd_pkg::RegTimeoutTicks, 32'h3);
   endtask

   // Raise warmup above the count to resume warmup ticks, then release it.
   task automatic test_warmup_reentry();
      write_register(ipd_pkg::RegWarmupTicks, 32'(det_warmup) + 32'd2);
      send_sample(16'h03FF);
      send_sample(16'h0000);
      send_sample(16'h03FF);
      wait_for_results();
      write_register(ipd_pkg::RegWarmupTicks, 32'hFFFF);
      send_sample(16'h0000);
      send_sample(16'h03FF);
      wait_for_results();
      write_register(ipd_pkg::RegWarmupTicks, 32'h0);
   endtask

   // Largest run: saturate the rising run on a flat signal, then confirm a
   // fall only after 255 falling samples.
   task automatic test_run_saturation();
      write_register(ipd_pkg::RegReversalRun, 32'hFF);
      write_register(ipd_pkg::RegTimeoutTicks, 32'd1000);
      send_constant(10'd512, 260);
      send_sample(16'h03FF);
      for (int i = 0; i < 260; i++) begin
         send_sample(16'(1022 - i));
      end
      wait_for_results();
      write_register(ipd_pkg::RegReversalRun, 32'h2);
   endtask

   // Long flat stretch between pulses: the largest timeout keeps counting,
   // a short one restarts the count.
   task automatic test_long_gap();
      write_register(ipd_pkg::RegReversalRun, 32'h1);
      write_register(ipd_pkg::RegTimeoutTicks, 32'hFFFF);
      send_constant(10'd1023, 100);
      send_sample(16'h0000);
      wait_for_results();
      write_register(ipd_pkg::RegTimeoutTicks, 32'd50);
      send_constant(10'd1023, 100);
      send_sample(16'h0000);
      wait_for_results();
   endtask

   // Alternate full scale so every sample is a pulse and the count climbs.
   task automatic test_pulse_train();
      write_register(ipd_pkg::RegTimeoutTicks, 32'h1);
      write_register(ipd_pkg::RegReversalRun, 32'h1);
      write_register(ipd_pkg::RegFilterAlpha, 32'hFFFF);
      for (int unsigned i = 0; i < 120; i++) begin
         send_sample((i % 2) ? 16'h0000 : 16'h03FF);
      end
      wait_for_results();
   endtask

   // Random settings per phase; mostly square waves with random period,
   // levels and noise, plus glitches and pure noise.
   task automatic test_random_traffic();
      int unsigned half, lo, hi, noise, mode, level, warmup;
      logic [ipd_pkg::AlphaBits-1:0] alpha;
      logic [ipd_pkg::TickBits-1:0] timeout;
      logic [ipd_pkg::RunBits-1:0] run;
      for (int phase = 0; phase < 8; phase++) begin
         wait_for_results();
         case ($urandom_range(7))
            0: alpha = '0;
            1: alpha = '1;
            default: alpha = ipd_pkg::AlphaBits'($urandom_range(65535, 8192));
         endcase
         case ($urandom_range(7))
            0: timeout = '0;
            1: timeout = 16'd1;
            2: timeout = '1;
            default: timeout = ipd_pkg::TickBits'($urandom_range(64, 1));
         endcase
         case ($urandom_range(15))
            0: run = '0;
            1: run = '1;
            default: run = ipd_pkg::RunBits'($urandom_range(4, 1));
         endcase
         warmup = ($urandom_range(2) == 0) ? 32'(det_warmup) + $urandom_range(10, 1) : 0;
         if (warmup > 65535) warmup = 65535;
         write_register(ipd_pkg::RegFilterAlpha, {16'($urandom), alpha});
         write_register(ipd_pkg::RegTimeoutTicks, {16'($urandom), timeout});
         write_register(ipd_pkg::RegReversalRun, {24'($urandom), run});
         write_register(ipd_pkg::RegWarmupTicks, {16'($urandom), 16'(warmup)});
         // Keep one phase free of any stall.
         send_idling = (phase != 3);
         recv_idling = (phase != 3);
         mode = $urandom_range(3);
         half = $urandom_range(24, 1);
         lo = $urandom_range(1023);
         hi = $urandom_range(1023);
         noise = (mode == 1) ? $urandom_range(64) : 0;
         for (int unsigned i = 0; i < 110; i++) begin
            if (mode == 3 || $urandom_range(31) == 0) begin
               level = $urandom_range(1023);
            end else begin
               level = (((i / half) % 2) ? hi : lo) + $urandom_range(noise);
               if (level > 1023) level = 1023;
            end
            send_sample({6'($urandom), 10'(level)});
            // Pause the sender once until the unit has drained.
            if (phase == 5 && i == 55) wait_for_results();
         end
      end
      send_idling = 1'b1;
      recv_idling = 1'b1;
   endtask

   initial begin
      cfg_alpha = ipd_pkg::AlphaReset;
      cfg_warmup = ipd_pkg::WarmupReset;
      cfg_timeout = ipd_pkg::TimeoutReset;
      cfg_run = ipd_pkg::RunReset;
      det_warmup = '0;
      det_filter = '0;
      det_previous = '0;
      det_fall_run = '0;
      det_rise_run = '0;
      det_slope = SlopeFalling;
      det_ticks = '0;
      det_pulses = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_warmup_hold();
      test_filter_extremes();
      test_zero_run();
      test_zero_timeout();
      test_warmup_reentry();
      test_run_saturation();
      test_long_gap();
      test_pulse_train();
      test_random_traffic();

      wait_for_results();
      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
